[rtl/ihl_pkg.sv]
// Package for the Intel HEX record loader.
// Holds the request, status and state codes and the controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none
package ihl_pkg;

  typedef enum logic [1:0] {
    REQ_TEXT  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_START = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_ADDRESS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHECK,
    S_COPY,
    S_EMIT
  } state_t;

  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] HEX_GAP     = 8'd7;
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_SSTART  = 8'h03;
  localparam logic [7:0] REC_LINEAR  = 8'h04;
  localparam logic [7:0] REC_LSTART  = 8'h05;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  typedef struct packed {
    logic    clear_all;
    logic    sweep;
    logic    take_char;
    logic    apply_rec;
    logic    clear_line;
    logic    set_halt;
    logic    calc_addr;
    logic    check_addr;
    logic    copy_step;
    logic    rd_issue;
    logic    load_out;
    logic    out_kind;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic is_lf;
    logic is_cr;
    logic fmt_err;
    logic is_data;
    logic overlong;
    logic addr_fail;
    logic copy_done;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/ihl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Used for the image store and the record buffer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ihl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/ihl_ctrl.sv]
// Controller state machine of the Intel HEX record loader.
// Depends on ihl_pkg; drives the datapath through cmd_t and watches sts_t.
`timescale 1ns / 1ps
`default_nettype none
module ihl_ctrl import ihl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  state_t  state, state_next;
  status_t stat, stat_next;
  logic    emit_pend, emit_pend_next;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      stat      <= ST_OK;
      emit_pend <= 1'b0;
    end else begin
      state     <= state_next;
      stat      <= stat_next;
      emit_pend <= emit_pend_next;
    end
  end

  assign in_ready = (state == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    stat_next      = stat;
    emit_pend_next = emit_pend;
    cmd            = '0;
    cmd.out_status = stat;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          emit_pend_next = 1'b0;
          stat_next      = ST_OK;
          state_next     = emit_pend ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_READ: begin
              cmd.rd_issue = 1'b1;
              state_next   = S_RD;
            end
            REQ_START: begin
              cmd.clear_all  = 1'b1;
              emit_pend_next = 1'b1;
              state_next     = S_CLEAR;
            end
            REQ_TEXT: begin
              if (!sts.halted && !sts.is_cr) begin
                if (sts.is_lf) begin
                  if (sts.fmt_err) begin
                    cmd.clear_line = 1'b1;
                    cmd.set_halt   = 1'b1;
                    stat_next      = ST_FORMAT;
                    state_next     = S_EMIT;
                  end else if (sts.is_data) begin
                    cmd.calc_addr = 1'b1;
                    state_next    = S_CHECK;
                  end else begin
                    cmd.apply_rec  = 1'b1;
                    cmd.clear_line = 1'b1;
                    stat_next      = ST_OK;
                    state_next     = S_EMIT;
                  end
                end else if (sts.overlong) begin
                  // The line is dropped anyway, so the last character is not parsed.
                  cmd.clear_line = 1'b1;
                  cmd.set_halt   = 1'b1;
                  stat_next      = ST_FORMAT;
                  state_next     = S_EMIT;
                end else begin
                  cmd.take_char = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.load_out   = 1'b1;
        cmd.out_kind   = 1'b1;
        cmd.out_status = ST_OK;
        state_next     = S_IDLE;
      end
      S_CHECK: begin
        if (sts.addr_fail) begin
          cmd.clear_line = 1'b1;
          cmd.set_halt   = 1'b1;
          stat_next      = ST_ADDRESS;
          state_next     = S_EMIT;
        end else begin
          cmd.check_addr = 1'b1;
          state_next     = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          cmd.clear_line = 1'b1;
          stat_next      = ST_OK;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/ihl_dp.sv]
// Datapath of the Intel HEX record loader: line parser, address unit,
// record buffer, image store, start registers and result register. Uses ihl_pkg, ihl_ram.
`timescale 1ns / 1ps
`default_nettype none
module ihl_dp import ihl_pkg::*; #(
  parameter int IMAGE_BYTES      = 65536,
  parameter int LINE_MAX_CHARS   = 544,
  parameter int RECORD_MAX_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [7:0]  char_code,
  input  wire logic [15:0] read_index,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [1:0]       status,
  output logic [7:0]       read_byte,
  output logic [31:0]      start_linear,
  output logic [15:0]      start_segment,
  output logic [15:0]      start_offset
);
  localparam int AW  = $clog2(IMAGE_BYTES);
  localparam int RAW = $clog2(RECORD_MAX_BYTES);

  logic [31:0] base_address;
  logic [16:0] image_size;

  logic [9:0]  line_chars;
  logic [3:0]  high_nibble;
  logic [7:0]  rec_length;
  logic [15:0] rec_offset;
  logic [7:0]  rec_kind;
  logic [7:0]  running_sum;
  logic [8:0]  bytes_seen;
  logic        colon_seen;
  logic [15:0] linear_base;
  logic [15:0] segment_base;
  logic        halted;
  logic [7:0]  first_bytes [4];

  logic [31:0]   addr;
  logic [AW-1:0] img_off;
  logic [8:0]    copy_cnt;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] sweep_cnt;
  logic          read_oor;

  logic [7:0]  digit, digit_raw, pair_byte;
  logic [8:0]  kd;
  logic [9:0]  rec_end;
  logic        rec_we;
  logic        copy_issue;
  logic [7:0]  img_rdata, rec_rdata;
  logic        img_we;
  logic [AW-1:0] img_waddr, img_raddr;
  logic [7:0]  img_wdata;
  logic [31:0] idx32;
  logic [32:0] size_eff, end_addr, lim_addr;

  // Digit rule: subtract '0', and a further 7 past nine; only 8 bits matter.
  assign digit_raw = char_code - CH_ZERO;
  assign digit     = (digit_raw > 8'd9) ? digit_raw - HEX_GAP : digit_raw;
  assign pair_byte = {high_nibble, 4'b0} | digit;
  assign kd        = bytes_seen - 9'd4;
  assign rec_end   = 10'd4 + 10'(rec_length);
  assign rec_we    = cmd.take_char && (line_chars != 10'd0) && !line_chars[0]
                     && (bytes_seen >= 9'd4) && (10'(bytes_seen) < rec_end)
                     && (32'(kd) < RECORD_MAX_BYTES);

  assign copy_issue = cmd.copy_step && (copy_cnt < 9'(rec_length));

  assign size_eff = (32'(image_size) < IMAGE_BYTES) ? 33'(image_size) : 33'(IMAGE_BYTES);
  assign end_addr = 33'(addr) + 33'(rec_length);
  assign lim_addr = 33'(base_address) + size_eff;

  assign sts.halted     = halted;
  assign sts.is_lf      = (char_code == CH_LF);
  assign sts.is_cr      = (char_code == CH_CR);
  assign sts.fmt_err    = (line_chars == 10'd0) || !colon_seen
                          || (10'(bytes_seen) < 10'd5 + 10'(rec_length))
                          || (running_sum != 8'd0)
                          || (32'(rec_length) > RECORD_MAX_BYTES)
                          || (((rec_kind == REC_SEGMENT) || (rec_kind == REC_LINEAR))
                              && (rec_length != 8'd2))
                          || (((rec_kind == REC_SSTART) || (rec_kind == REC_LSTART))
                              && (rec_length != 8'd4));
  assign sts.is_data    = (rec_kind == REC_DATA);
  assign sts.overlong   = (11'(line_chars) + 11'd1 >= 11'(LINE_MAX_CHARS));
  assign sts.addr_fail  = (addr < base_address) || (end_addr > lim_addr);
  assign sts.copy_done  = (copy_cnt == 9'(rec_length)) && !wr_pend;
  assign sts.sweep_last = (sweep_cnt == AW'(IMAGE_BYTES - 1));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      image_size   <= 17'd65536;
    end else if (cfg_valid) begin
      if (cfg_index) begin
        image_size <= cfg_data[16:0];
      end else begin
        base_address <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      line_chars    <= '0;
      high_nibble   <= '0;
      rec_length    <= '0;
      rec_offset    <= '0;
      rec_kind      <= '0;
      running_sum   <= '0;
      bytes_seen    <= '0;
      colon_seen    <= 1'b0;
      linear_base   <= '0;
      segment_base  <= '0;
      start_linear  <= '0;
      start_segment <= '0;
      start_offset  <= '0;
      halted        <= 1'b0;
      sweep_cnt     <= '0;
      wr_pend       <= 1'b0;
      copy_cnt      <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
      if (cmd.take_char) begin
        line_chars <= line_chars + 10'd1;
        if (line_chars == 10'd0) begin
          colon_seen <= (char_code == CH_COLON);
        end else if (line_chars[0]) begin
          high_nibble <= digit[3:0];
        end else begin
          case (bytes_seen)
            9'd0: rec_length <= pair_byte;
            9'd1: rec_offset[15:8] <= pair_byte;
            9'd2: rec_offset[7:0] <= pair_byte;
            9'd3: rec_kind <= pair_byte;
            default: ;
          endcase
          if (rec_we && (kd < 9'd4)) begin
            first_bytes[kd[1:0]] <= pair_byte;
          end
          if (10'(bytes_seen) <= rec_end) begin
            running_sum <= running_sum + pair_byte;
          end
          if (bytes_seen != 9'd511) begin
            bytes_seen <= bytes_seen + 9'd1;
          end
        end
      end
      if (cmd.apply_rec) begin
        case (rec_kind)
          REC_SEGMENT: segment_base <= {first_bytes[0], first_bytes[1]};
          REC_LINEAR:  linear_base  <= {first_bytes[0], first_bytes[1]};
          REC_SSTART: begin
            start_segment <= {first_bytes[0], first_bytes[1]};
            start_offset  <= {first_bytes[2], first_bytes[3]};
          end
          REC_LSTART: begin
            start_linear <= {first_bytes[0], first_bytes[1], first_bytes[2], first_bytes[3]};
          end
          default: ;
        endcase
      end
      if (cmd.calc_addr) begin
        copy_cnt <= '0;
        wr_pend  <= 1'b0;
      end
      if (cmd.copy_step) begin
        wr_pend <= copy_issue;
        wr_addr <= img_off + AW'(copy_cnt);
        if (copy_issue) begin
          copy_cnt <= copy_cnt + 9'd1;
        end
      end
      if (cmd.clear_line) begin
        line_chars  <= '0;
        high_nibble <= '0;
        rec_length  <= '0;
        rec_offset  <= '0;
        rec_kind    <= '0;
        running_sum <= '0;
        bytes_seen  <= '0;
        colon_seen  <= 1'b0;
      end
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
    end
  end

  // Address unit: the segment/linear sum is registered, then checked and rebased.
  always_ff @(posedge clk) begin
    if (cmd.calc_addr) begin
      addr <= {linear_base, 16'b0} + {12'b0, segment_base, 4'b0} + {16'b0, rec_offset};
    end
    if (cmd.check_addr) begin
      img_off <= AW'(addr - base_address);
    end
  end

  assign idx32 = {16'b0, read_index};

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      read_oor <= (idx32 >= IMAGE_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_kind <= cmd.out_kind;
      status      <= cmd.out_status;
      read_byte   <= !cmd.out_kind ? 8'd0 : (read_oor ? FILL_BYTE : img_rdata);
    end
  end

  assign img_we    = cmd.sweep || wr_pend;
  assign img_waddr = cmd.sweep ? sweep_cnt : wr_addr;
  assign img_wdata = cmd.sweep ? FILL_BYTE : rec_rdata;
  assign img_raddr = idx32[AW-1:0];

  ihl_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  ihl_ram #(.WIDTH(8), .DEPTH(RECORD_MAX_BYTES)) u_record (
    .clk   (clk),
    .we    (rec_we),
    .waddr (kd[RAW-1:0]),
    .wdata (pair_byte),
    .raddr (copy_cnt[RAW-1:0]),
    .rdata (rec_rdata)
  );
endmodule
`default_nettype wire

[rtl/intel_hex_record_loader.sv]
// Top level of the Intel HEX record loader: controller plus datapath.
// Depends on ihl_pkg, ihl_ctrl, ihl_dp and ihl_ram.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, char_code, read_index
//   out      output     out_valid / out_ready result_kind, status, read_byte,
//                                             start_linear, start_segment, start_offset
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A line feed that ends a data record is followed by the one-byte-a-cycle copy
// from the record buffer into the image store. An image read goes through the
// registered image store read and then the output register.
// After reset and after each start item the image store is filled with 0xFF
// at one byte a cycle, with no item accepted meanwhile.
// A result waits in the output register; the next item is taken once it drains.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_loader import ihl_pkg::*; #(
  parameter int IMAGE_BYTES      = 65536,
  parameter int LINE_MAX_CHARS   = 544,
  parameter int RECORD_MAX_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  char_code,
  input  wire logic [15:0] read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [1:0]       status,
  output logic [7:0]       read_byte,
  output logic [31:0]      start_linear,
  output logic [15:0]      start_segment,
  output logic [15:0]      start_offset,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ihl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihl_dp #(
    .IMAGE_BYTES      (IMAGE_BYTES),
    .LINE_MAX_CHARS   (LINE_MAX_CHARS),
    .RECORD_MAX_BYTES (RECORD_MAX_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .char_code     (char_code),
    .read_index    (read_index),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .status        (status),
    .read_byte     (read_byte),
    .start_linear  (start_linear),
    .start_segment (start_segment),
    .start_offset  (start_offset)
  );
endmodule
`default_nettype wire

[rtl/ihl_checker.sv]
// Port-level checks for the Intel HEX record loader, bound to the top level.
// Depends on ihl_pkg for the request and status codes.
`timescale 1ns / 1ps
`default_nettype none
module ihl_checker import ihl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        result_kind,
  input wire logic [1:0]  status,
  input wire logic [7:0]  read_byte
);
  // A held result must not change its status or data byte under a stall.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte))
    else $error("result changed while stalled");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> status == ST_OK)
    else $error("read result carries a nonzero status");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind |-> read_byte == 8'd0)
    else $error("status result carries a data byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  // A start item begins the fill pass, during which no item is taken.
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_START |=> !in_ready)
    else $error("item taken right after a start item");
endmodule

bind intel_hex_record_loader ihl_checker u_ihl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .req_type    (req_type),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .status      (status),
  .read_byte   (read_byte)
);
`default_nettype wire
